@@ src/gco_pkg.sv @@
// ----------------------------------------------------------------------------
// gco_pkg
// Shared constants and types of the greedy connectivity ordering core.
// ----------------------------------------------------------------------------
package gco_pkg;

  localparam int MAX_NODES = 256;
  localparam int ID_W      = 8;
  localparam int CNT_W     = 9;
  localparam int KEY_W     = 2 * CNT_W;
  localparam int WORD_W    = 64;
  localparam int WSEL_W    = 2;
  localparam int BSEL_W    = 6;
  localparam int ADJ_AW    = ID_W + WSEL_W;

  localparam logic [1:0] KIND_CLAUSE = 2'd0;
  localparam logic [1:0] KIND_ORDER  = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic             init;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  pos;
    logic [ID_W-1:0]  node;
  } cand_t;

endpackage

@@ src/greedy_connectivity_order_core.sv @@
// ----------------------------------------------------------------------------
// greedy_connectivity_order_core
// Loads two-literal clauses as an adjacency bit matrix, orders variables by
// maximum cardinality search and answers position queries.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  in       in_kind .. in_slot                      start, busy
//  out      out_position_out, out_done_res          out_valid strobe
//  cfg      cfg_node_count                          cfg_valid, cfg_ready
//
//  A clause that is not of length two with magnitudes below 256 is only acknowledged.
//  Run: clear of live counts and positions, degree scan, search for the chosen
//  node, then per placed node a row sweep and a scan of the remaining slots, then position writes.
//  After reset a clearing pass sweeps all 1024 words of the adjacency memory;
//  busy is high meanwhile. One adjacency, count or order port bounds all steps.
//  Results cannot be stalled; each is shown for one cycle.
// ----------------------------------------------------------------------------
module greedy_connectivity_order_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [1:0]        in_clause_len,
  input  logic signed [8:0] in_lit_a,
  input  logic signed [8:0] in_lit_b,
  input  logic [7:0]        in_node,
  input  logic [7:0]        in_slot,
  output logic              out_valid,
  output logic [7:0]        out_position_out,
  output logic              out_done_res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [8:0]        cfg_node_count
);

  localparam int ID_W   = gco_pkg::ID_W;
  localparam int CNT_W  = gco_pkg::CNT_W;
  localparam int ADJ_AW = gco_pkg::ADJ_AW;
  localparam int DEPTH  = 1 << ID_W;
  localparam logic [CNT_W-1:0] NODE_CAP = CNT_W'(gco_pkg::MAX_NODES);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_C_RD1, S_C_WR1, S_C_RD2, S_C_WR2, S_Q_OUT, S_RCLR,
    S_DG_RD, S_DG_CMP, S_FD_RD, S_FD_CHK, S_SW_RD, S_SW_WA, S_SW_WB,
    S_CR_RDW, S_CR_LDW, S_CR_BIT, S_CR_INC, S_NEXT, S_SC_RO, S_SC_RL,
    S_SC_CMP, S_SC_END, S_FN_RD, S_FN_WR
  } state_t;

  logic [gco_pkg::WORD_W-1:0] adj_mem  [1 << ADJ_AW];
  logic [CNT_W-1:0]           deg_mem  [DEPTH];
  logic [CNT_W-1:0]           live_mem [DEPTH];
  logic [ID_W-1:0]            ord_mem  [DEPTH];
  logic [ID_W-1:0]            fpos_mem [DEPTH];

  logic [gco_pkg::WORD_W-1:0] adj_q, adj_wdata, word_r, word_nxt;
  logic [CNT_W-1:0]           deg_q, live_q, deg_wdata, live_wdata;
  logic [ID_W-1:0]            ord_q, fpos_q, ord_wdata, fpos_wdata;
  logic [ADJ_AW-1:0]          adj_raddr, adj_waddr;
  logic [ID_W-1:0]            deg_raddr, deg_waddr, live_raddr, live_waddr;
  logic [ID_W-1:0]            ord_raddr, ord_waddr, fpos_waddr;
  logic                       adj_we, deg_we, live_we, ord_we, fpos_we;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]     cfg_n_r;
  logic [CNT_W-1:0]     n_eff;
  logic [ADJ_AW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt, j_r, j_nxt, j_inc;
  logic [gco_pkg::WSEL_W-1:0] w_r, w_nxt;
  logic [gco_pkg::BSEL_W-1:0] k_r, k_nxt;
  logic [ID_W-1:0]      a_r, a_nxt, b_r, b_nxt, sw_pos_r, sw_pos_nxt;
  logic [8:0]           mag_a, mag_b;
  logic                 accept, j_more, bit_clear1, bit_clear2;
  gco_pkg::cand_t       cand;
  logic [ID_W-1:0]      best_pos, best_node;

  gco_best u_best (
    .clk       (clk),
    .cand      (cand),
    .best_pos  (best_pos),
    .best_node (best_node)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign n_eff     = (cfg_n_r > NODE_CAP) ? NODE_CAP : cfg_n_r;
  assign j_inc     = j_r + CNT_W'(1);
  assign j_more    = (j_inc < n_eff);
  assign mag_a     = in_lit_a[8] ? (9'd0 - in_lit_a) : in_lit_a;
  assign mag_b     = in_lit_b[8] ? (9'd0 - in_lit_b) : in_lit_b;
  assign bit_clear1 = !adj_q[b_r[5:0]];
  assign bit_clear2 = !adj_q[a_r[5:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= NODE_CAP;
    end else if (cfg_valid && cfg_ready) begin
      cfg_n_r <= cfg_node_count;
    end
  end

  // read addresses
  always_comb begin
    adj_raddr  = {best_node, w_r};
    deg_raddr  = j_r[ID_W-1:0];
    live_raddr = {w_r, k_r};
    ord_raddr  = j_r[ID_W-1:0];
    case (state_r)
      S_C_RD1: begin
        adj_raddr = {a_r, b_r[7:6]};
        deg_raddr = a_r;
      end
      S_C_RD2: begin
        adj_raddr = {b_r, a_r[7:6]};
        deg_raddr = b_r;
      end
      S_SC_RL: begin
        deg_raddr  = ord_q;
        live_raddr = ord_q;
      end
      S_SW_RD: ord_raddr = i_r[ID_W-1:0];
      default: ;
    endcase
  end

  // write ports
  always_comb begin
    adj_we = 1'b0;  adj_waddr = idx_r;  adj_wdata = '0;
    deg_we = 1'b0;  deg_waddr = idx_r[ID_W-1:0];  deg_wdata = '0;
    live_we = 1'b0; live_waddr = idx_r[ID_W-1:0]; live_wdata = '0;
    fpos_we = 1'b0; fpos_waddr = idx_r[ID_W-1:0]; fpos_wdata = '0;
    ord_we = 1'b0;  ord_waddr = in_slot;  ord_wdata = in_node;
    case (state_r)
      S_CLR: begin
        adj_we = 1'b1;
        deg_we  = (idx_r[ADJ_AW-1:ID_W] == '0);
        live_we = deg_we;
        fpos_we = deg_we;
      end
      S_IDLE: ord_we = accept && (in_kind == gco_pkg::KIND_ORDER);
      S_C_WR1: begin
        adj_we    = bit_clear1;
        adj_waddr = {a_r, b_r[7:6]};
        adj_wdata = adj_q | (64'd1 << b_r[5:0]);
        deg_we    = bit_clear1;
        deg_waddr = a_r;
        deg_wdata = deg_q + CNT_W'(1);
      end
      S_C_WR2: begin
        adj_we    = bit_clear2;
        adj_waddr = {b_r, a_r[7:6]};
        adj_wdata = adj_q | (64'd1 << a_r[5:0]);
        deg_we    = bit_clear2;
        deg_waddr = b_r;
        deg_wdata = deg_q + CNT_W'(1);
      end
      S_RCLR: begin
        live_we = 1'b1;
        fpos_we = 1'b1;
      end
      S_SW_WA: begin
        ord_we = 1'b1; ord_waddr = sw_pos_r; ord_wdata = ord_q;
      end
      S_SW_WB: begin
        ord_we = 1'b1; ord_waddr = i_r[ID_W-1:0]; ord_wdata = best_node;
      end
      S_CR_INC: begin
        live_we = 1'b1; live_waddr = {w_r, k_r}; live_wdata = live_q + CNT_W'(1);
      end
      S_FN_WR: begin
        fpos_we = 1'b1; fpos_waddr = ord_q; fpos_wdata = j_r[ID_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    live_q <= live_mem[live_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (fpos_we) begin
      fpos_mem[fpos_waddr] <= fpos_wdata;
    end
    fpos_q <= fpos_mem[in_node];
  end

  // compare unit feed
  always_comb begin
    cand.valid = 1'b0;
    cand.init  = 1'b0;
    cand.key   = {{CNT_W{1'b0}}, deg_q};
    cand.pos   = j_r[ID_W-1:0];
    cand.node  = j_r[ID_W-1:0];
    case (state_r)
      S_DG_CMP: begin
        cand.valid = 1'b1;
        cand.init  = (j_r == '0);
      end
      S_SC_CMP: begin
        cand.valid = 1'b1;
        cand.init  = (j_r == i_r);
        cand.key   = {live_q, deg_q};
        cand.node  = a_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = '0;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sw_pos_nxt    = sw_pos_r;
    word_nxt      = word_r;
    case (state_r)
      S_CLR: begin
        idx_nxt = idx_r + ADJ_AW'(1);
        if (idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            gco_pkg::KIND_CLAUSE: begin
              a_nxt = mag_a[ID_W-1:0];
              b_nxt = mag_b[ID_W-1:0];
              if ((in_clause_len == 2'd2) && !mag_a[8] && !mag_b[8]) begin
                state_nxt = S_C_RD1;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            gco_pkg::KIND_ORDER: out_valid_nxt = 1'b1;
            gco_pkg::KIND_RUN: begin
              idx_nxt   = '0;
              state_nxt = S_RCLR;
            end
            default: state_nxt = S_Q_OUT;
          endcase
        end
      end
      S_C_RD1: state_nxt = S_C_WR1;
      S_C_WR1: state_nxt = S_C_RD2;
      S_C_RD2: state_nxt = S_C_WR2;
      S_C_WR2: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_Q_OUT: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = fpos_q;
        state_nxt     = S_IDLE;
      end
      S_RCLR: begin
        idx_nxt = idx_r + ADJ_AW'(1);
        if (idx_r[ID_W-1:0] == '1) begin
          j_nxt = '0;
          if (n_eff < CNT_W'(2)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_DG_RD;
          end
        end
      end
      S_DG_RD: state_nxt = S_DG_CMP;
      S_DG_CMP: begin
        if (j_more) begin
          j_nxt     = j_inc;
          state_nxt = S_DG_RD;
        end else begin
          i_nxt     = CNT_W'(1);
          j_nxt     = CNT_W'(1);
          state_nxt = S_FD_RD;
        end
      end
      S_FD_RD: state_nxt = S_FD_CHK;
      S_FD_CHK: begin
        if (ord_q == best_node) begin
          sw_pos_nxt = j_r[ID_W-1:0];
          state_nxt  = S_SW_RD;
        end else if (j_more) begin
          j_nxt     = j_inc;
          state_nxt = S_FD_RD;
        end else begin
          w_nxt     = '0;
          state_nxt = S_CR_RDW;
        end
      end
      S_SW_RD: state_nxt = S_SW_WA;
      S_SW_WA: state_nxt = S_SW_WB;
      S_SW_WB: begin
        w_nxt     = '0;
        state_nxt = S_CR_RDW;
      end
      S_CR_RDW: state_nxt = S_CR_LDW;
      S_CR_LDW: begin
        word_nxt  = adj_q;
        k_nxt     = '0;
        state_nxt = S_CR_BIT;
      end
      S_CR_BIT, S_CR_INC: begin
        if ((state_r == S_CR_BIT) && word_r[k_r]) begin
          state_nxt = S_CR_INC;
        end else if (k_r == '1) begin
          if (w_r == '1) begin
            state_nxt = S_NEXT;
          end else begin
            w_nxt     = w_r + 2'd1;
            state_nxt = S_CR_RDW;
          end
        end else begin
          k_nxt     = k_r + 6'd1;
          state_nxt = S_CR_BIT;
        end
      end
      S_NEXT: begin
        if (({1'b0, i_r} + 10'd2) < {1'b0, n_eff}) begin
          i_nxt     = i_r + CNT_W'(1);
          j_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SC_RO;
        end else begin
          j_nxt     = CNT_W'(1);
          state_nxt = S_FN_RD;
        end
      end
      S_SC_RO: state_nxt = S_SC_RL;
      S_SC_RL: begin
        a_nxt     = ord_q;
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (j_more) begin
          j_nxt     = j_inc;
          state_nxt = S_SC_RO;
        end else begin
          state_nxt = S_SC_END;
        end
      end
      S_SC_END: begin
        sw_pos_nxt = best_pos;
        state_nxt  = S_SW_RD;
      end
      S_FN_RD: state_nxt = S_FN_WR;
      S_FN_WR: begin
        if (j_more) begin
          j_nxt     = j_inc;
          state_nxt = S_FN_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    out_pos_r <= out_pos_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    w_r       <= w_nxt;
    k_r       <= k_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    sw_pos_r  <= sw_pos_nxt;
    word_r    <= word_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_done_res     = 1'b1;

`ifndef ASSERT_OFF
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted request neither running nor answered");

  a_pos_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_position_out != 8'd0)) |-> $past(state_r == S_Q_OUT))
    else $error("nonzero position outside query");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || accept))
    else $error("result without request");
`endif

endmodule

@@ src/gco_best.sv @@
// ----------------------------------------------------------------------------
// gco_best
// Shared compare unit: keeps the best candidate seen in the current scan.
// ----------------------------------------------------------------------------
module gco_best (
  input  logic                       clk,
  input  gco_pkg::cand_t             cand,
  output logic [gco_pkg::ID_W-1:0]   best_pos,
  output logic [gco_pkg::ID_W-1:0]   best_node
);

  logic [gco_pkg::KEY_W-1:0] best_key_r;
  logic [gco_pkg::ID_W-1:0]  best_pos_r;
  logic [gco_pkg::ID_W-1:0]  best_node_r;
  logic                      take;

  assign take = cand.valid && (cand.init || (cand.key > best_key_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_key_r  <= cand.key;
      best_pos_r  <= cand.pos;
      best_node_r <= cand.node;
    end
  end

  assign best_pos  = best_pos_r;
  assign best_node = best_node_r;

endmodule
